FILE: sv/blp_pkg.sv
// Shared types for the line point generator: controller state,
// controller-to-datapath commands and datapath status.
// No dependencies.
`default_nettype none

package blp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } blp_state_t;

  typedef struct packed {
    logic load;   // capture endpoints of an accepted request
    logic setup;  // derive deltas, direction and initial error
    logic step;   // advance to the next point
  } blp_cmd_t;

  typedef struct packed {
    logic zero_len;  // endpoints are equal, line has no points
    logic last;      // current point is the final one
  } blp_stat_t;

endpackage

`default_nettype wire

FILE: sv/blp_if.sv
// Valid/ready channel interfaces: line request and line point.
// Depends on nothing; width follows COORD_BITS.
`default_nettype none

interface blp_req_if #(parameter int COORD_BITS = 6);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

interface blp_pt_if #(parameter int COORD_BITS = 6);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, output point_x, output point_y,
                  output last_point, input ready);
  modport sink   (input valid, input point_x, input point_y,
                  input last_point, output ready);
endinterface

`default_nettype wire

FILE: sv/blp_ctrl.sv
// Controller for the line point generator: idle, setup and run states.
// Depends on blp_pkg for the state type and command/status structs.
`default_nettype none

module blp_ctrl import blp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  blp_stat_t stat,
  output blp_cmd_t  cmd
);

  blp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        // drop straight back when the endpoints coincide
        state_nxt = stat.zero_len ? ST_IDLE : ST_RUN;
      end
      ST_RUN: begin
        if (out_ready && stat.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_RUN: begin
        out_valid = 1'b1;
        cmd.step  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/blp_dp.sv
// Datapath for the line point generator: endpoint capture, setup of the
// Bresenham deltas and error, and the per-point stepper.
// Depends on blp_pkg for the command/status structs.
`default_nettype none

module blp_dp import blp_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  logic                  clk,
  input  blp_cmd_t              cmd,
  output blp_stat_t             stat,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic [COORD_BITS-1:0] point_x,
  output logic [COORD_BITS-1:0] point_y,
  output logic                  last_point
);

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 3;  // signed error, covers +/- 4*max delta

  logic [C-1:0] ax_r, ay_r, bx_r, by_r;
  logic [C-1:0] maj_r, min_r, cnt_r, dmaj_r, dmin_r;
  logic         xmaj_r, neg_r;
  logic [E-1:0] err_r;

  // setup terms from the captured endpoints
  logic [C-1:0] adx, ady, maj0, min0, min1, dmaj, dmin;
  logic         xmaj, swap;
  logic [E-1:0] err0;

  always_comb begin
    adx  = (ax_r >= bx_r) ? ax_r - bx_r : bx_r - ax_r;
    ady  = (ay_r >= by_r) ? ay_r - by_r : by_r - ay_r;
    xmaj = ady < adx;
    if (xmaj) begin
      swap = ax_r > bx_r;
      maj0 = swap ? bx_r : ax_r;
      min0 = swap ? by_r : ay_r;
      min1 = swap ? ay_r : by_r;
      dmaj = adx;
      dmin = ady;
    end else begin
      swap = ay_r > by_r;
      maj0 = swap ? by_r : ay_r;
      min0 = swap ? bx_r : ax_r;
      min1 = swap ? ax_r : bx_r;
      dmaj = ady;
      dmin = adx;
    end
    err0 = {2'b00, dmin, 1'b0} - {3'b000, dmaj};
  end

  // stepper terms
  logic         err_pos;
  logic [E-1:0] err_nxt;
  logic [C-1:0] min_nxt;

  always_comb begin
    err_pos = !err_r[E-1] && (err_r != '0);
    err_nxt = err_r + {2'b00, dmin_r, 1'b0}
              - (err_pos ? {2'b00, dmaj_r, 1'b0} : {E{1'b0}});
    if (!err_pos) begin
      min_nxt = min_r;
    end else if (neg_r) begin
      min_nxt = min_r - {{(C-1){1'b0}}, 1'b1};
    end else begin
      min_nxt = min_r + {{(C-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= start_x;
      ay_r <= start_y;
      bx_r <= end_x;
      by_r <= end_y;
    end
    if (cmd.setup) begin
      xmaj_r <= xmaj;
      neg_r  <= min1 < min0;
      maj_r  <= maj0;
      min_r  <= min0;
      cnt_r  <= dmaj;
      dmaj_r <= dmaj;
      dmin_r <= dmin;
      err_r  <= err0;
    end else if (cmd.step) begin
      maj_r <= maj_r + {{(C-1){1'b0}}, 1'b1};
      min_r <= min_nxt;
      cnt_r <= cnt_r - {{(C-1){1'b0}}, 1'b1};
      err_r <= err_nxt;
    end
  end

  assign stat.zero_len = (ax_r == bx_r) && (ay_r == by_r);
  assign stat.last     = cnt_r == {{(C-1){1'b0}}, 1'b1};

  assign point_x    = xmaj_r ? maj_r : min_r;
  assign point_y    = xmaj_r ? min_r : maj_r;
  assign last_point = stat.last;

endmodule

`default_nettype wire

FILE: sv/bresenham_line_points_top.sv
// Line point generator: one request with two endpoints in, the Bresenham
// raster points out, one beat per point in rising major-axis order, the
// endpoint with the larger major-axis coordinate excluded. The first point
// follows the request beat after a setup state. The single point stepper
// serves one line until its last point is taken; equal endpoints give none.
// Reset: rst_n synchronous active low returns the controller to idle.
`default_nettype none

module bresenham_line_points_top import blp_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  blp_req_if.sink  in_req,
  blp_pt_if.source out_pt
);

  blp_cmd_t  cmd;
  blp_stat_t stat;

  blp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_pt.valid),
    .out_ready (out_pt.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  blp_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .stat       (stat),
    .start_x    (in_req.start_x),
    .start_y    (in_req.start_y),
    .end_x      (in_req.end_x),
    .end_y      (in_req.end_y),
    .point_x    (out_pt.point_x),
    .point_y    (out_pt.point_y),
    .last_point (out_pt.last_point)
  );

endmodule

`default_nettype wire

FILE: sv/blp_checker.sv
// Port-level checks for the line point generator, bound to the top level.
// Depends on the top level's channel ports only.
`default_nettype none

module blp_checker #(
  parameter int COORD_BITS = 6
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] point_x,
  input logic [COORD_BITS-1:0] point_y,
  input logic                  last_point
);

  // one line at a time: never take a request while points are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while points pending");

  // a request beat is followed by a setup cycle with both sides closed
  a_setup_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("no setup cycle after request beat");

  // points of one line come without gaps until the last one
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_point) |=> out_valid)
    else $error("line ended before last point");

  // a stalled point holds
  a_point_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(point_x) && $stable(point_y) && $stable(last_point)))
    else $error("stalled point changed");

endmodule

bind bresenham_line_points_top blp_checker #(.COORD_BITS(COORD_BITS)) u_blp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_pt.valid),
  .out_ready  (out_pt.ready),
  .point_x    (out_pt.point_x),
  .point_y    (out_pt.point_y),
  .last_point (out_pt.last_point)
);

`default_nettype wire
